// File: rtl/cbo_pkg.sv
// ----------------------------------------------------------------------------
// cbo_pkg: shared types and constants
// Payload structs, register indexes and fixed widths for the cell/bin overlap
// block.
// ----------------------------------------------------------------------------
package cbo_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        size_x;
    logic [30:0]        size_y;
  } cell_t;

  typedef struct packed {
    logic [15:0] bin_x_base;
    logic [15:0] bin_y_base;
    logic [2:0]  col_offset;
    logic [2:0]  row_offset;
    logic [31:0] area;
    logic        last;
  } result_t;

  localparam logic [2:0] REG_ORIGIN_X       = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y       = 3'd1;
  localparam logic [2:0] REG_BIN_WIDTH      = 3'd2;
  localparam logic [2:0] REG_BIN_HEIGHT     = 3'd3;
  localparam logic [2:0] REG_INV_BIN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_INV_BIN_HEIGHT = 3'd5;
  localparam logic [2:0] REG_OVERLAP_SCALE  = 3'd6;

  // Width of the signed coordinate datapath; bin edges reach about 2^48.
  localparam int LW = 51;
  // Width of one scaled axis overlap.
  localparam int SCW = 47;
  // Register stages from an accepted cell to its axis overlaps.
  localparam int FRONT_LAT = 7;
  localparam logic [16:0] IDX_CAP = 17'd65536;
  localparam logic [15:0] IDX_MAX = 16'hFFFF;

endpackage

// File: rtl/cbo_axis.sv
// ----------------------------------------------------------------------------
// cbo_axis: first bin and scaled overlaps on one axis
// Seven-stage pipeline: offset, reciprocal estimate, edge product,
// correction, base edge, per-bin clipping, scaling.
// ----------------------------------------------------------------------------
module cbo_axis import cbo_pkg::*; #(
  parameter int NB = 8
) (
  input  logic                      clk,
  input  logic signed [31:0]        p,
  input  logic [30:0]               size,
  input  logic [31:0]               o,
  input  logic [31:0]               b,
  input  logic [31:0]               r,
  input  logic [31:0]               scale,
  output logic [15:0]               idx,
  output logic [NB-1:0][SCW-1:0]    ov
);

  logic [LW-1:0] o_ext;
  logic [LW-1:0] b_ext;

  // Stage 1
  logic [32:0]   d1;
  logic [LW-1:0] p1, end1;
  // Stage 2
  logic [23:0]   est2;
  logic [LW-1:0] p2, end2;
  logic [63:0]   prod2;
  // Stage 3
  logic [16:0]   idx3;
  logic [48:0]   e3;
  logic [LW-1:0] p3, end3;
  logic [16:0]   cap3;
  // Stage 4
  logic [15:0]   idx4;
  logic [LW-1:0] p4, end4;
  logic [LW-1:0] t4, tb4;
  logic          up4, dn4;
  logic [17:0]   adj4;
  // Stage 5
  logic [LW-1:0] left5, p5, end5;
  logic [15:0]   idx5;
  // Stage 6
  logic [NB-1:0][30:0] ov6;
  logic [15:0]   idx6;
  // Stage 7
  logic [15:0]   idx7;
  logic [NB-1:0][SCW-1:0] sc7;

  assign o_ext = {{(LW-32){o[31]}}, o};
  assign b_ext = {{(LW-32){1'b0}}, b};

  always_ff @(posedge clk) begin
    d1   <= {p[31], p} - {o[31], o};
    p1   <= {{(LW-32){p[31]}}, p};
    end1 <= {{(LW-32){p[31]}}, p} + {{(LW-31){1'b0}}, size};
  end

  // A positive offset is below 2^32, so its low 32 bits carry it exactly.
  assign prod2 = d1[31:0] * r;

  always_ff @(posedge clk) begin
    est2 <= (!d1[32] && d1 != 33'd0) ? prod2[63:40] : 24'd0;
    p2   <= p1;
    end2 <= end1;
  end

  assign cap3 = (est2 > {7'd0, IDX_CAP}) ? IDX_CAP : est2[16:0];

  always_ff @(posedge clk) begin
    idx3 <= cap3;
    e3   <= cap3 * b;
    p3   <= p2;
    end3 <= end2;
  end

  // t4 = o + idx*b - p; the estimate moves down if that edge lies right of p,
  // otherwise up if the next edge is still at or left of p.
  assign t4  = o_ext + {{(LW-49){1'b0}}, e3} - p3;
  assign tb4 = t4 + b_ext;
  assign dn4 = !t4[LW-1] && t4 != '0;
  assign up4 = tb4[LW-1] || tb4 == '0;

  always_comb begin
    if (dn4) begin
      adj4 = (idx3 == 17'd0) ? 18'd0 : {1'b0, idx3} - 18'd1;
    end else if (up4) begin
      adj4 = {1'b0, idx3} + 18'd1;
    end else begin
      adj4 = {1'b0, idx3};
    end
  end

  always_ff @(posedge clk) begin
    idx4 <= (adj4 > {2'b0, IDX_MAX}) ? IDX_MAX : adj4[15:0];
    p4   <= p3;
    end4 <= end3;
  end

  always_ff @(posedge clk) begin
    left5 <= o_ext + {{(LW-48){1'b0}}, 48'(idx4) * 48'(b)};
    p5    <= p4;
    end5  <= end4;
    idx5  <= idx4;
  end

  for (genvar j = 0; j < NB; j++) begin : g_lane
    logic [LW-1:0] left_j, right_j, lo_j, hi_j, diff_j;
    assign left_j  = left5 + LW'(j) * b_ext;
    assign right_j = left_j + b_ext;
    assign lo_j    = ($signed(p5) > $signed(left_j)) ? p5 : left_j;
    assign hi_j    = ($signed(end5) < $signed(right_j)) ? end5 : right_j;
    assign diff_j  = hi_j - lo_j;

    always_ff @(posedge clk) begin
      // The clipped overlap never exceeds the cell size, so 31 bits hold it.
      ov6[j] <= (diff_j[LW-1] || diff_j == '0) ? 31'd0 : diff_j[30:0];
    end

    logic [62:0] scp_j;
    assign scp_j = ov6[j] * scale;

    always_ff @(posedge clk) begin
      sc7[j] <= scp_j[62:16];
    end
  end

  always_ff @(posedge clk) begin
    idx6 <= idx5;
    idx7 <= idx6;
  end

  assign idx = idx7;
  assign ov  = sc7;

endmodule

// File: rtl/cbo_emit.sv
// ----------------------------------------------------------------------------
// cbo_emit: area product sequencer
// Holds one cell being emitted and one waiting, walks all column/row pairs
// and multiplies the overlaps in a three-stage product pipeline.
// ----------------------------------------------------------------------------
module cbo_emit import cbo_pkg::*; #(
  parameter int NB = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   front_valid,
  input  logic [15:0]            front_bx,
  input  logic [15:0]            front_by,
  input  logic [NB-1:0][SCW-1:0] front_ovx,
  input  logic [NB-1:0][SCW-1:0] front_ovy,
  output logic                   done,
  output logic                   result_valid,
  output result_t                result
);

  localparam int CW = (NB > 1) ? $clog2(NB) : 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(NB - 1);

  logic                   active, pend_v;
  logic [15:0]            cur_bx, cur_by, pend_bx, pend_by;
  logic [NB-1:0][SCW-1:0] cur_ovx, cur_ovy, pend_ovx, pend_ovy;
  logic [CW-1:0]          j, k;
  logic                   finish, free;

  assign finish = active && j == LAST_IDX && k == LAST_IDX;
  assign free   = !active || finish;
  assign done   = finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pend_v <= 1'b0;
      j      <= '0;
      k      <= '0;
    end else begin
      if (free) begin
        j <= '0;
        k <= '0;
        if (pend_v) begin
          active <= 1'b1;
          pend_v <= front_valid;
        end else begin
          active <= front_valid;
        end
      end else begin
        if (k == LAST_IDX) begin
          k <= '0;
          j <= j + CW'(1);
        end else begin
          k <= k + CW'(1);
        end
        if (front_valid) begin
          pend_v <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free && pend_v) begin
      cur_bx  <= pend_bx;
      cur_by  <= pend_by;
      cur_ovx <= pend_ovx;
      cur_ovy <= pend_ovy;
    end else if (free) begin
      cur_bx  <= front_bx;
      cur_by  <= front_by;
      cur_ovx <= front_ovx;
      cur_ovy <= front_ovy;
    end
    if (front_valid && !(free && !pend_v)) begin
      pend_bx  <= front_bx;
      pend_by  <= front_by;
      pend_ovx <= front_ovx;
      pend_ovy <= front_ovy;
    end
  end

  // Product pipeline: select, partial products, sum and saturate.
  logic            v0, v1;
  logic [SCW-1:0]  a0, b0;
  result_t         m0, m1;
  logic [47:0]     ll1;
  logic [46:0]     lh1, hl1;
  logic [45:0]     hh1;
  logic [93:0]     sum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0           <= 1'b0;
      v1           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      v0           <= active;
      v1           <= v0;
      result_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    a0            <= cur_ovx[j];
    b0            <= cur_ovy[k];
    m0.bin_x_base <= cur_bx;
    m0.bin_y_base <= cur_by;
    m0.col_offset <= 3'(j);
    m0.row_offset <= 3'(k);
    m0.area       <= '0;
    m0.last       <= finish;
  end

  always_ff @(posedge clk) begin
    ll1 <= a0[23:0] * b0[23:0];
    lh1 <= a0[23:0] * b0[46:24];
    hl1 <= a0[46:24] * b0[23:0];
    hh1 <= a0[46:24] * b0[46:24];
    m1  <= m0;
  end

  assign sum2 = {hh1, 48'd0} + {22'd0, {1'b0, lh1} + {1'b0, hl1}, 24'd0}
              + {46'd0, ll1};

  always_ff @(posedge clk) begin
    result.bin_x_base <= m1.bin_x_base;
    result.bin_y_base <= m1.bin_y_base;
    result.col_offset <= m1.col_offset;
    result.row_offset <= m1.row_offset;
    result.last       <= m1.last;
    // Products of 2^48 or more saturate the Q16.16 area.
    result.area       <= (sum2[93:48] != '0) ? 32'hFFFF_FFFF : sum2[47:16];
  end

endmodule

// File: rtl/cell_bin_overlap_area.sv
// ----------------------------------------------------------------------------
// cell_bin_overlap_area: placement density cell-to-bin overlap areas
// Computes the clipped overlap of one placed cell with a block of bins and
// emits every column/row area product.
// ----------------------------------------------------------------------------
// Usage:
//   A cell transaction is taken on a rising edge with start high and busy
//   low. Each cell yields OVERLAP_BINS*OVERLAP_BINS results, one per cycle
//   on result with result_valid high for one cycle, columns outer and rows
//   inner; the final one has last set. The receiver cannot stall.
//   The first result reaches the result ports through seven stages for the
//   per-axis bin search and clipping, one load into the emitter, one select
//   stage and a two-stage split 47x47 multiplier for the area. Cells are
//   emitted one after another over the single result channel. One further
//   cell may be accepted while another is being emitted; busy is high while
//   two cells are in the block.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high and should be used only while the block is idle.
//   Unknown indexes are ignored. Synchronous reset restores register defaults
//   and drops all cells in flight.
// ----------------------------------------------------------------------------
module cell_bin_overlap_area import cbo_pkg::*; #(
  parameter int OVERLAP_BINS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cell_t       item,
  output logic        result_valid,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] origin_x, origin_y, bin_width, bin_height;
  logic [31:0] inv_bin_width, inv_bin_height, overlap_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= 32'd0;
      origin_y       <= 32'd0;
      bin_width      <= 32'd256000;
      bin_height     <= 32'd256000;
      inv_bin_width  <= 32'd4294967;
      inv_bin_height <= 32'd4294967;
      overlap_scale  <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_X:       origin_x       <= cfg_data;
        REG_ORIGIN_Y:       origin_y       <= cfg_data;
        REG_BIN_WIDTH:      bin_width      <= cfg_data;
        REG_BIN_HEIGHT:     bin_height     <= cfg_data;
        REG_INV_BIN_WIDTH:  inv_bin_width  <= cfg_data;
        REG_INV_BIN_HEIGHT: inv_bin_height <= cfg_data;
        REG_OVERLAP_SCALE:  overlap_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                             accept, done;
  logic [1:0]                       in_flight;
  logic [FRONT_LAT-1:0]             vpipe;
  logic [15:0]                      bx, by;
  logic [OVERLAP_BINS-1:0][SCW-1:0] ovx, ovy;

  assign accept = start && !busy;
  assign busy   = in_flight == 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 2'd0;
      vpipe     <= '0;
    end else begin
      in_flight <= in_flight + {1'b0, accept} - {1'b0, done};
      vpipe     <= {vpipe[FRONT_LAT-2:0], accept};
    end
  end

  cbo_axis #(.NB(OVERLAP_BINS)) u_axis_x (
    .clk   (clk),
    .p     (item.pos_x),
    .size  (item.size_x),
    .o     (origin_x),
    .b     (bin_width),
    .r     (inv_bin_width),
    .scale (overlap_scale),
    .idx   (bx),
    .ov    (ovx)
  );

  cbo_axis #(.NB(OVERLAP_BINS)) u_axis_y (
    .clk   (clk),
    .p     (item.pos_y),
    .size  (item.size_y),
    .o     (origin_y),
    .b     (bin_height),
    .r     (inv_bin_height),
    .scale (overlap_scale),
    .idx   (by),
    .ov    (ovy)
  );

  cbo_emit #(.NB(OVERLAP_BINS)) u_emit (
    .clk          (clk),
    .rst          (rst),
    .front_valid  (vpipe[FRONT_LAT-1]),
    .front_bx     (bx),
    .front_by     (by),
    .front_ovx    (ovx),
    .front_ovy    (ovy),
    .done         (done),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
